// ----- hdl/color_ramp_gradient_sampler_core_assert.svh -----
// Assertion macros shared by the checker of the color ramp sampler.
// No dependencies.
`ifndef COLOR_RAMP_GRADIENT_SAMPLER_CORE_ASSERT_SVH
`define COLOR_RAMP_GRADIENT_SAMPLER_CORE_ASSERT_SVH
// Checks a property at every rising clock edge outside of reset.
`define CRGS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("failed");
// Checks that a condition brings a result in the same cycle.
`define CRGS_ASSERT_IMPLY(label, cond, res) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (res)) \
    else $error("implication failed");
`endif

// ----- hdl/crgs_pkg.sv -----
// Package for the color ramp sampler: payload types, constants and states.
// No dependencies.
`timescale 1ns / 1ps
package crgs_pkg;
  localparam int MaxStops = 8;
  localparam logic [16:0] WidthReset = 17'd256;
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdSample = 1'b1;
  localparam logic [1:0] StColor = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StInserted = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic command;
    logic [15:0] position;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic [15:0] texel_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [3:0] stop_total;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic [32:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_PDIV, S_SEARCH, S_LOAD, S_CHAN, S_CDIV, S_DONE
  } state_t;
endpackage

// ----- hdl/color_ramp_gradient_sampler_core.sv -----
// Top level of the color ramp sampler: stop table, sequencer, output register.
// Depends on crgs_pkg, crgs_multiplier and crgs_divider.
`timescale 1ns / 1ps
// An insert into a table that is not full moves each larger stop up one slot and
// then writes the new stop, and a sample of an empty ramp goes straight to the result.
// Any other sample first works out the position: a 16-step serial multiply and then
// a 33-step serial divide. The stop search then examines one stop per cycle, and an
// interpolated sample runs a multiply and a divide for each of the four channels.
// One word is worked on at a time, and the next word is accepted no earlier than the
// cycle after the result has been taken.
module color_ramp_gradient_sampler_core #(
  parameter int MAX_STOPS = crgs_pkg::MaxStops
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crgs_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crgs_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [16:0]          cfg_data
);
  localparam int IW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);

  logic [15:0] pos_mem [MAX_STOPS];
  logic [31:0] col_mem [MAX_STOPS];
  logic [CW-1:0] count;
  logic [16:0] width;
  crgs_pkg::state_t state, state_next;
  crgs_pkg::in_word_t item;
  logic [CW-1:0] slot;
  logic [15:0] pos;
  logic [31:0] ca, cb, color;
  logic [15:0] p0, p1;
  logic [1:0] ch;
  logic [8:0] diff;
  logic neg;
  logic mstart, mbusy, dbusy, mwait;
  logic [32:0] prod, quo;
  crgs_pkg::div_req_t dreq;
  logic [16:0] wm1;
  logic [15:0] idx;
  logic [7:0] c0, c1, cres;
  logic [16:0] num;
  logic go;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != crgs_pkg::S_IDLE) || out_valid;
  assign go = in_valid && !in_stall;
  assign wm1 = ((width < 17'd2) ? 17'd2 : width) - 17'd1;
  assign idx = ({1'b0, item.texel_index} > wm1) ? wm1[15:0] : item.texel_index;
  assign c0 = ca[8*ch +: 8];
  assign c1 = cb[8*ch +: 8];
  assign diff = (c1 >= c0) ? {1'b0, c1 - c0} : {1'b0, c0 - c1};
  assign neg = c1 < c0;
  assign num = {1'b0, pos - p0};
  assign cres = neg ? c0 - quo[7:0] : c0 + quo[7:0];

  crgs_multiplier u_mul (
    .clk(clk), .rst(rst), .start(mstart),
    .a(state == crgs_pkg::S_SHIFT ? {1'b0, idx} : {8'd0, diff}),
    .b(state == crgs_pkg::S_SHIFT ? 16'hFFFF : num[15:0]),
    .busy(mbusy), .product(prod)
  );
  crgs_divider u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quotient(quo));

  always_comb begin
    state_next = state;
    unique case (state)
      crgs_pkg::S_IDLE: begin
        if (go) begin
          state_next = crgs_pkg::S_SHIFT;
        end
      end
      crgs_pkg::S_SHIFT: begin
        if (item.command == crgs_pkg::CmdSample) begin
          state_next = (count == '0) ? crgs_pkg::S_DONE : crgs_pkg::S_PDIV;
        end else if (count == CW'(MAX_STOPS) || slot == '0 ||
                     pos_mem[IW'(slot - 1'b1)] <= item.position) begin
          state_next = crgs_pkg::S_DONE;
        end
      end
      crgs_pkg::S_PDIV: begin
        if (!mwait && !dbusy && !dreq.start) begin
          state_next = crgs_pkg::S_SEARCH;
        end
      end
      crgs_pkg::S_SEARCH: begin
        if (slot == count || pos_mem[IW'(slot)] >= pos) begin
          state_next = (slot == count || slot == '0) ? crgs_pkg::S_DONE : crgs_pkg::S_LOAD;
        end
      end
      crgs_pkg::S_LOAD: state_next = crgs_pkg::S_CHAN;
      crgs_pkg::S_CHAN: begin
        if (!mwait && !dbusy && !dreq.start) begin
          state_next = (ch == 2'd3) ? crgs_pkg::S_DONE : crgs_pkg::S_LOAD;
        end
      end
      crgs_pkg::S_DONE: state_next = crgs_pkg::S_IDLE;
      default: state_next = crgs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mstart = 1'b0;
    unique case (state)
      crgs_pkg::S_SHIFT: mstart = (item.command == crgs_pkg::CmdSample) && (count != '0);
      crgs_pkg::S_LOAD: mstart = 1'b1;
      default: mstart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crgs_pkg::S_IDLE;
      count <= '0;
      width <= crgs_pkg::WidthReset;
      out_valid <= 1'b0;
      mwait <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        width <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (mstart) begin
        mwait <= 1'b1;
      end else if (mwait && !mbusy) begin
        mwait <= 1'b0;
      end
      dreq.start <= mwait && !mbusy && !mstart;
      unique case (state)
        crgs_pkg::S_IDLE: begin
          item <= in_data;
          slot <= count;
          color <= '0;
          ch <= 2'd0;
        end
        crgs_pkg::S_SHIFT: begin
          if (item.command == crgs_pkg::CmdSample) begin
            dreq.dividend <= '0;
            dreq.divisor <= wm1;
          end else if (count != CW'(MAX_STOPS)) begin
            if (slot != '0 && pos_mem[IW'(slot - 1'b1)] > item.position) begin
              pos_mem[IW'(slot)] <= pos_mem[IW'(slot - 1'b1)];
              col_mem[IW'(slot)] <= col_mem[IW'(slot - 1'b1)];
              slot <= slot - 1'b1;
            end else begin
              pos_mem[IW'(slot)] <= item.position;
              col_mem[IW'(slot)] <= {item.in_red, item.in_green, item.in_blue, item.in_alpha};
              count <= count + 1'b1;
            end
          end
        end
        crgs_pkg::S_PDIV: begin
          slot <= '0;
          if (mwait && !mbusy) begin
            dreq.dividend <= prod;
          end
          if (state_next == crgs_pkg::S_SEARCH) begin
            pos <= quo[15:0];
          end
        end
        crgs_pkg::S_SEARCH: begin
          if (slot == count) begin
            color <= col_mem[IW'(count - 1'b1)];
          end else if (pos_mem[IW'(slot)] >= pos) begin
            color <= col_mem[IW'(slot)];
            p1 <= pos_mem[IW'(slot)];
            cb <= col_mem[IW'(slot)];
            if (slot != '0) begin
              p0 <= pos_mem[IW'(slot - 1'b1)];
              ca <= col_mem[IW'(slot - 1'b1)];
            end
          end else begin
            slot <= slot + 1'b1;
          end
        end
        crgs_pkg::S_LOAD: begin
          dreq.divisor <= {1'b0, p1 - p0};
        end
        crgs_pkg::S_CHAN: begin
          if (mwait && !mbusy) begin
            dreq.dividend <= prod;
          end
          if (!mwait && !dbusy && !dreq.start) begin
            color[8*ch +: 8] <= cres;
            ch <= ch + 2'd1;
          end
        end
        crgs_pkg::S_DONE: begin
          out_valid <= 1'b1;
          out_data.stop_total <= 4'(count);
          out_data.out_red <= color[31:24];
          out_data.out_green <= color[23:16];
          out_data.out_blue <= color[15:8];
          out_data.out_alpha <= color[7:0];
          if (item.command == crgs_pkg::CmdInsert) begin
            out_data.status <= (slot == CW'(MAX_STOPS)) ? crgs_pkg::StFull
                                                         : crgs_pkg::StInserted;
          end else if (count == '0) begin
            out_data.status <= crgs_pkg::StEmpty;
          end else begin
            out_data.status <= crgs_pkg::StColor;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/crgs_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on crgs_pkg.
`timescale 1ns / 1ps
module crgs_divider (
  input  logic              clk,
  input  logic              rst,
  input  crgs_pkg::div_req_t req,
  output logic              busy,
  output logic [32:0]       quotient
);
  logic [16:0] rem;
  logic [32:0] quo;
  logic [16:0] dsr;
  logic [5:0] cnt;
  logic [17:0] trial;

  assign trial = {rem, quo[32]} - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 6'd33;
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      if (!trial[17]) begin
        rem <= trial[16:0];
      end else begin
        rem <= {rem[15:0], quo[32]};
      end
      quo <= {quo[31:0], ~trial[17]};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- hdl/crgs_multiplier.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module crgs_multiplier (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] a,
  input  logic [15:0] b,
  output logic        busy,
  output logic [32:0] product
);
  logic [15:0] mb;
  logic [32:0] ma;
  logic [4:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'd16;
      product <= '0;
      ma <= {16'd0, a};
      mb <= b;
    end else if (busy) begin
      if (mb[0]) begin
        product <= product + ma;
      end
      ma <= {ma[31:0], 1'b0};
      mb <= {1'b0, mb[15:1]};
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- hdl/crgs_checker.sv -----
// Port-level checker for the color ramp sampler, bound to the top level.
// Depends on crgs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "color_ramp_gradient_sampler_core_assert.svh"
module crgs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input crgs_pkg::out_word_t out_data
);
  logic no_color;
  logic [7:0] any_color;

  assign no_color = out_valid && (out_data.status != crgs_pkg::StColor);
  assign any_color = out_data.out_red | out_data.out_green | out_data.out_blue |
                     out_data.out_alpha;

  `CRGS_ASSERT(a_one_word, (in_valid && !in_stall) |=> in_stall)
  `CRGS_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
  `CRGS_ASSERT_IMPLY(a_count, out_valid, out_data.stop_total <= 4'd8)
  `CRGS_ASSERT_IMPLY(a_zero, no_color, any_color == 8'd0)
endmodule

bind color_ramp_gradient_sampler_core crgs_checker u_chk (.*);

// ----- tb/sv/tb_color_ramp_gradient_sampler_core.sv -----
// Testbench for color_ramp_gradient_sampler_core: directed and random stop inserts and
// texel samples, checked against an in-bench gradient predictor. Depends on crgs_pkg
// and the RTL of the sampler core.
`timescale 1ns / 1ps
module tb_color_ramp_gradient_sampler_core;
  localparam int CycleLimit = 4000000;
  localparam int Drain = 300;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  crgs_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  crgs_pkg::out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [16:0] cfg_data;

  color_ramp_gradient_sampler_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [15:0] ramp_pos [crgs_pkg::MaxStops];
  logic [31:0] ramp_rgba [crgs_pkg::MaxStops];
  int unsigned ramp_count;
  logic [16:0] ramp_width;

  crgs_pkg::out_word_t color_queue [$];
  int unsigned failures = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned samples_sent = 0;
  int unsigned cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  function automatic logic [7:0] lerp8(logic [7:0] c0, logic [7:0] c1,
                                       longint num, longint den);
    longint dlt;
    longint v;
    dlt = longint'(c1) - longint'(c0);
    v = longint'(c0) + (dlt * num) / den;
    return v[7:0];
  endfunction

  function automatic crgs_pkg::out_word_t predict_color(crgs_pkg::in_word_t w);
    crgs_pkg::out_word_t r;
    int unsigned slot;
    int unsigned k;
    longint wd;
    longint idx;
    longint pos;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    r = '0;
    c = '0;
    if (w.command == crgs_pkg::CmdInsert) begin
      if (ramp_count >= crgs_pkg::MaxStops) begin
        r.status = crgs_pkg::StFull;
      end else begin
        slot = ramp_count;
        while (slot > 0 && ramp_pos[slot-1] > w.position) begin
          ramp_pos[slot] = ramp_pos[slot-1];
          ramp_rgba[slot] = ramp_rgba[slot-1];
          slot--;
        end
        ramp_pos[slot] = w.position;
        ramp_rgba[slot] = {w.in_red, w.in_green, w.in_blue, w.in_alpha};
        ramp_count++;
        r.status = crgs_pkg::StInserted;
      end
    end else if (ramp_count == 0) begin
      r.status = crgs_pkg::StEmpty;
    end else begin
      wd = (ramp_width < 2) ? 2 : longint'(ramp_width);
      idx = longint'(w.texel_index);
      if (idx > wd - 1) idx = wd - 1;
      pos = (idx * 65535) / (wd - 1);
      k = 0;
      while (k < ramp_count && longint'(ramp_pos[k]) < pos) k++;
      if (k >= ramp_count) begin
        c = ramp_rgba[ramp_count-1];
      end else if (k == 0) begin
        c = ramp_rgba[0];
      end else begin
        a = ramp_rgba[k-1];
        b = ramp_rgba[k];
        for (int sh = 0; sh < 32; sh += 8) begin
          c[sh +: 8] = lerp8(a[sh +: 8], b[sh +: 8], pos - longint'(ramp_pos[k-1]),
                             longint'(ramp_pos[k]) - longint'(ramp_pos[k-1]));
        end
      end
      r.status = crgs_pkg::StColor;
      {r.out_red, r.out_green, r.out_blue, r.out_alpha} = c;
    end
    r.stop_total = ramp_count[3:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on word %0d: %s got %0d expected %0d", words_checked, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    crgs_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (color_queue.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = color_queue.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.out_red !== want.out_red)
          report_mismatch("red", out_data.out_red, want.out_red);
        if (out_data.out_green !== want.out_green)
          report_mismatch("green", out_data.out_green, want.out_green);
        if (out_data.out_blue !== want.out_blue)
          report_mismatch("blue", out_data.out_blue, want.out_blue);
        if (out_data.out_alpha !== want.out_alpha)
          report_mismatch("alpha", out_data.out_alpha, want.out_alpha);
        if (out_data.stop_total !== want.stop_total)
          report_mismatch("stop total", out_data.stop_total, want.stop_total);
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL color_ramp_gradient_sampler_core");
      $finish;
    end
  end

  task automatic send_word(crgs_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    color_queue = {color_queue, predict_color(w)};
    words_sent++;
    if (w.command == crgs_pkg::CmdSample) samples_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic crgs_pkg::in_word_t make_word(logic cmd, logic [15:0] p,
                                                   logic [31:0] rgba, logic [15:0] idx);
    crgs_pkg::in_word_t w;
    w.command = cmd;
    w.position = p;
    {w.in_red, w.in_green, w.in_blue, w.in_alpha} = rgba;
    w.texel_index = idx;
    return w;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (color_queue.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_width(logic [16:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ramp_width = v;
  endtask

  task automatic test_empty_ramp();
    send_word(make_word(crgs_pkg::CmdSample, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0000, 32'h0000_0000, 16'hFFFF));
  endtask

  task automatic test_insert_order();
    send_word(make_word(crgs_pkg::CmdInsert, 16'h8000, 32'h10_20_30_40, 16'hFFFF));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'd64));
    send_word(make_word(crgs_pkg::CmdInsert, 16'h8000, 32'hF0_E0_D0_C0, 16'h0));
    send_word(make_word(crgs_pkg::CmdInsert, 16'h0000, 32'h00_00_00_00, 16'h0));
    send_word(make_word(crgs_pkg::CmdInsert, 16'hFFFF, 32'hFF_FF_FF_FF, 16'h0));
  endtask

  task automatic test_sample_extremes();
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'd0));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'd1));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'd127));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'd128));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'd200));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'd255));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'hFFFF));
  endtask

  task automatic test_full_table();
    while (ramp_count < crgs_pkg::MaxStops)
      send_word(make_word(crgs_pkg::CmdInsert, 16'($urandom), $urandom, 16'($urandom)));
    send_word(make_word(crgs_pkg::CmdInsert, 16'h4000, 32'hAA_55_AA_55, 16'h0));
    send_word(make_word(crgs_pkg::CmdSample, 16'h0, 32'h0, 16'd100));
  endtask

  task automatic test_random(int unsigned n, int unsigned tx_pct, int unsigned rx_pct);
    crgs_pkg::in_word_t w;
    int unsigned span;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      w = make_word(($urandom_range(99) < 80) ? crgs_pkg::CmdSample : crgs_pkg::CmdInsert,
                    16'($urandom), $urandom, 16'($urandom));
      span = (ramp_width < 2) ? 2 : ((ramp_width > 65536) ? 65536 : ramp_width);
      if ($urandom_range(1)) w.texel_index = 16'($urandom_range(span - 1));
      if ($urandom_range(9) == 0) w.position = $urandom_range(1) ? 16'hFFFF : 16'h0;
      send_word(w);
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    ramp_count = 0;
    ramp_width = crgs_pkg::WidthReset;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_ramp();
    test_insert_order();
    test_sample_extremes();
    test_random(300, 16, 85);
    test_full_table();
    write_width(17'd2);
    test_random(300, 16, 85);
    write_width(17'd65536);
    test_random(300, 85, 16);
    write_width(17'd1);
    test_random(150, 85, 16);
    write_width(17'd0);
    test_random(150, 85, 16);
    write_width(17'h1FFFF);
    test_random(200, 0, 0);
    write_width(17'($urandom_range(3, 4000)));
    test_random(200, 0, 0);
    write_width(17'd256);
    test_random(200, 0, 0);
    wait_idle();
    $display("Sent %0d words (%0d samples) and checked %0d results over seven width settings.",
             words_sent, samples_sent, words_checked);
    if (failures == 0) begin
      $display("PASS color_ramp_gradient_sampler_core");
    end else begin
      $display("FAIL color_ramp_gradient_sampler_core");
    end
    $finish;
  end
endmodule

// ----- color_ramp_gradient_sampler_core.f -----
+incdir+hdl
hdl/crgs_pkg.sv
hdl/crgs_divider.sv
hdl/crgs_multiplier.sv
hdl/color_ramp_gradient_sampler_core.sv
hdl/crgs_checker.sv
tb/sv/tb_color_ramp_gradient_sampler_core.sv
